// ===== hdl/mf_pkg.sv =====
// Shared widths, register indexes, types and compare helpers of the 3x3 median filter.
`default_nettype none

package mf_pkg;

    localparam int PIX_W         = 8;
    localparam int ROW_W         = 16;
    localparam int COL_W         = 10;
    localparam int IMG_W_BITS    = 11;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int WIN_DIM       = 3;
    localparam int MIN_DIM       = 3;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef logic [PIX_W-1:0] pix_t;

    // One window column, kept sorted from smallest to largest
    typedef struct packed {
        pix_t lo;
        pix_t mid;
        pix_t hi;
    } col_t;

    // Position and frame flag that travel beside a window through the pipeline
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } meta_t;

    function automatic pix_t pmin(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t pmax(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        return pmin(pmin(a, b), c);
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        return pmax(pmax(a, b), c);
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return pmax(pmin(a, b), pmin(pmax(a, b), c));
    endfunction

    // Three compare-exchange steps put a column in order
    function automatic col_t sort3(input col_t x);
        pix_t a;
        pix_t b;
        pix_t c;
        pix_t t;
        a = x.lo;
        b = x.mid;
        c = x.hi;
        t = pmin(a, b);
        b = pmax(a, b);
        a = t;
        t = pmin(b, c);
        c = pmax(b, c);
        b = t;
        t = pmin(a, b);
        b = pmax(a, b);
        a = t;
        return '{lo: a, mid: b, hi: c};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mf_col_cell.sv =====
// One column cell of the window chain: sorts the incoming column and holds it.
`default_nettype none

module mf_col_cell (
    input  wire logic         clk,
    input  wire logic         shift_en,
    input  wire mf_pkg::col_t col_in,
    output mf_pkg::col_t      col_out
);
    import mf_pkg::*;

    col_t col_reg;

    // Take the neighbour's column in sorted order on each shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            col_reg <= sort3(col_in);
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

// ===== hdl/mf_median.sv =====
// Two-stage median of nine from three sorted columns; the second stage is the output register.
`default_nettype none

module mf_median (
    input  wire logic         clk,
    input  wire logic         adv,
    input  wire mf_pkg::col_t win [mf_pkg::WIN_DIM],
    output mf_pkg::pix_t      median_out
);
    import mf_pkg::*;

    pix_t lo_reg;
    pix_t mid_reg;
    pix_t hi_reg;
    pix_t med_reg;

    // Largest minimum, middle median, smallest maximum, then their median
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg  <= max3(win[0].lo, win[1].lo, win[2].lo);
            mid_reg <= med3(win[0].mid, win[1].mid, win[2].mid);
            hi_reg  <= min3(win[0].hi, win[1].hi, win[2].hi);
            med_reg <= med3(lo_reg, mid_reg, hi_reg);
        end
    end

    assign median_out = med_reg;

endmodule

`default_nettype wire

// ===== hdl/median_filter_3x3.sv =====
// 3x3 median filter over a raster pixel stream: line stores, column cell chain, median stages.
//
// Pixels enter on in_valid/in_stall/pixel_in, one per request, row by row. For each pixel
// at row r >= 2 and column c >= 2 a result request leaves on out_valid/out_stall with the
// median of the nine pixels around (r-1, c-1), that position, and frame_last on the last
// interior pixel of the frame. Border pixels produce no request.
// Throughput is one pixel per cycle while out_stall holds no waiting result. A result passes
// through the registered line store read, the column cell chain and the two median stages
// (max/med/min stage, then the output register).
// Every stage moves on one enable (column cells also need a valid pixel); while out_stall
// holds a waiting result the whole pipeline holds and in_stall is raised, so no request is lost.
// The configuration port is always ready; a write to image_width or image_height takes
// effect at once and restarts the frame at row 0, column 0. Write it only while idle.
// Widths use the low 11 bits of the data; below 3 read as 3, above MAX_WIDTH as MAX_WIDTH;
// heights below 3 read as 3. Reset clears the position counters and valid flags and restores
// 640 x 480, the width capped at MAX_WIDTH. The line stores need no clearing pass: an entry
// is always written before any emitted window reads it.
`default_nettype none

module median_filter_3x3 #(
    parameter int MAX_WIDTH = mf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [mf_pkg::PIX_W-1:0]       pixel_in,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [mf_pkg::PIX_W-1:0]            median_out,
    output logic [mf_pkg::ROW_W-1:0]            out_row,
    output logic [mf_pkg::COL_W-1:0]            out_col,
    output logic                                frame_last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mf_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int EW    = (WW > IMG_W_BITS) ? WW : IMG_W_BITS;
    localparam int RST_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic             adv;
    logic             accept;
    logic             cfg_we;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    w_last_reg, w_last_next;
    logic [ROW_W-1:0] h_last_reg, h_last_next;

    logic [EW-1:0]    w_req;
    logic [EW-1:0]    w_clamp;
    logic [CW-1:0]    w_last_cfg;
    logic [ROW_W-1:0] h_req;
    logic [ROW_W-1:0] h_last_cfg;

    logic             a_emit;
    meta_t            a_meta;

    pix_t             line_a_mem [MAX_WIDTH];
    pix_t             line_b_mem [MAX_WIDTH];
    pix_t             rd_a_reg;
    pix_t             rd_b_reg;
    logic             wr_en;

    logic             s1_valid_reg;
    logic             s1_emit_reg;
    pix_t             s1_pix_reg;
    logic [CW-1:0]    s1_addr_reg;
    meta_t            s1_meta_reg;
    logic             s2_vld_reg;
    meta_t            s2_meta_reg;
    logic             s3_vld_reg;
    meta_t            s3_meta_reg;
    logic             out_valid_reg;
    meta_t            out_meta_reg;

    logic             shift_en;
    col_t             cell_in  [WIN_DIM];
    col_t             cell_out [WIN_DIM];

    // Handshakes: the pipeline moves unless a finished result is held
    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign accept    = in_valid && adv;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Clamp configured dimensions, kept as last index
    always_comb
    begin
        w_req = EW'(cfg_data[IMG_W_BITS-1:0]);
        if (w_req < EW'(MIN_DIM))
        begin
            w_clamp = EW'(MIN_DIM);
        end
        else if (w_req > EW'(MAX_WIDTH))
        begin
            w_clamp = EW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = w_req;
        end
        w_last_cfg = CW'(w_clamp - EW'(1));
        h_req      = cfg_data[ROW_W-1:0];
        h_last_cfg = (h_req < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM - 1) : h_req - ROW_W'(1);
    end

    // Advance raster position; a configuration write restarts the frame
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    w_last_next = w_last_cfg;
                    col_next    = '0;
                    row_next    = '0;
                end
                REG_IMAGE_HEIGHT:
                begin
                    h_last_next = h_last_cfg;
                    col_next    = '0;
                    row_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (col_reg == w_last_reg)
            begin
                col_next = '0;
                row_next = (row_reg == h_last_reg) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            w_last_reg <= CW'(RST_W - 1);
            h_last_reg <= ROW_W'(HEIGHT_RESET - 1);
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
        end
    end

    // Position of the window centre for the incoming pixel
    always_comb
    begin
        a_emit      = (row_reg >= ROW_W'(2)) && (col_reg >= CW'(2));
        a_meta.row  = row_reg - ROW_W'(1);
        a_meta.col  = COL_W'(col_reg - CW'(1));
        a_meta.last = (row_reg == h_last_reg) && (col_reg == w_last_reg);
    end

    // Line stores: read the column on accept, write it back from the first-stage registers
    assign wr_en = adv && s1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_a_reg <= line_a_mem[col_reg];
            rd_b_reg <= line_b_mem[col_reg];
        end
        if (wr_en)
        begin
            line_a_mem[s1_addr_reg] <= s1_pix_reg;
            line_b_mem[s1_addr_reg] <= rd_a_reg;
        end
    end

    // Valid flags through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s2_vld_reg    <= s1_valid_reg && s1_emit_reg;
            s3_vld_reg    <= s2_vld_reg;
            out_valid_reg <= s3_vld_reg;
        end
    end

    // Pixel, address and position alongside
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_emit_reg  <= a_emit;
            s1_pix_reg   <= pixel_in;
            s1_addr_reg  <= col_reg;
            s1_meta_reg  <= a_meta;
            s2_meta_reg  <= s1_meta_reg;
            s3_meta_reg  <= s2_meta_reg;
            out_meta_reg <= s3_meta_reg;
        end
    end

    // Window: chain of column cells, newest column enters cell 0
    assign shift_en   = adv && s1_valid_reg;
    assign cell_in[0] = '{lo: rd_b_reg, mid: rd_a_reg, hi: s1_pix_reg};

    genvar k;
    generate
        for (k = 0; k < WIN_DIM; k++)
        begin : g_cell
            if (k > 0)
            begin : g_link
                assign cell_in[k] = cell_out[k-1];
            end
            mf_col_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .col_in   (cell_in[k]),
                .col_out  (cell_out[k])
            );
        end
    endgenerate

    mf_median u_median (
        .clk        (clk),
        .adv        (adv),
        .win        (cell_out),
        .median_out (median_out)
    );

    assign out_valid  = out_valid_reg;
    assign out_row    = out_meta_reg.row;
    assign out_col    = out_meta_reg.col;
    assign frame_last = out_meta_reg.last;

    // Checks on the position counters and the pipeline
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= w_last_reg)
        else $error("column counter beyond row end");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel missing from first stage");

    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_last |->
            (out_row == h_last_reg - ROW_W'(1)) &&
            (out_col == COL_W'(w_last_reg - CW'(1))))
        else $error("frame end flagged at wrong position");

endmodule

`default_nettype wire
